>>> rtl/lssm_pkg.sv
// ----------------------------------------------------------------------------
// lssm_pkg
// Types, constants and helper functions shared by the line substring scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package lssm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
    localparam int LEN_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PAT_REGS    = 4;
    localparam int PAT_W       = CFG_DATA_W * PAT_REGS;

    // The result queue holds entries of up to two results each.
    // Q_DEPTH must be a power of two.
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = Q_PTR_W + 1;

    localparam logic [7:0]  CR_BYTE  = 8'h0D;
    localparam logic [7:0]  LF_BYTE  = 8'h0A;
    localparam logic [15:0] COL_MAX  = 16'hFFFF;
    localparam logic [31:0] LINE_MAX = 32'hFFFF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_PAT_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAT_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CASE  = 3'd5;

    // How many line bytes enter the window for one accepted input byte.
    typedef enum logic [1:0] {
        SHIFT_NONE,
        SHIFT_ONE,
        SHIFT_TWO
    } t_shift;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } t_in;

    typedef struct packed {
        logic [31:0] line_no;
        logic [15:0] start_column;
        logic        last_of_run;
    } t_out;

    // Window compare results handed from the cell row to the line tracker.
    typedef struct packed {
        t_shift shift;
        logic   hit_a;
        logic   hit_b;
        logic   is_lf;
        logic   eof;
    } t_scan;

    // One queue entry: both results of one input byte share its line.
    typedef struct packed {
        logic [31:0] line;
        logic [15:0] col_a;
        logic [15:0] col_b;
        logic        two;
    } t_entry;

    function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic fold_en);
        logic [7:0] r;
        r = b;
        if (fold_en && (b >= 8'h41) && (b <= 8'h5A)) begin
            r = b + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/lssm_cell.sv
// ----------------------------------------------------------------------------
// lssm_cell
// One position of the recent-byte window with its pattern compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire lssm_pkg::t_shift i_shift,
    input  wire logic [7:0]      i_prev1,
    input  wire logic [7:0]      i_prev2,
    input  wire logic [7:0]      i_pat,
    input  wire logic            i_fold_en,
    output logic [7:0]           o_byte,
    output logic                 o_eq_a,
    output logic                 o_eq_b
);
    import lssm_pkg::*;

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // i_prev1 is this position after a one-byte shift, i_prev2 after two.
    always_comb begin
        case (i_shift)
            SHIFT_NONE: n_byte = r_byte;
            SHIFT_ONE:  n_byte = i_prev1;
            SHIFT_TWO:  n_byte = i_prev2;
            default:    n_byte = r_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= 8'h00;
        end else begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;
    assign o_eq_a = (fold_byte(i_prev1, i_fold_en) == i_pat);
    assign o_eq_b = (fold_byte(i_prev2, i_fold_en) == i_pat);

endmodule

`default_nettype wire

>>> rtl/lssm_track.sv
// ----------------------------------------------------------------------------
// lssm_track
// Line, column and overlap bookkeeping; turns window hits into results.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_track (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    input  wire lssm_pkg::t_scan        i_scan,
    input  wire logic [lssm_pkg::LEN_W-1:0] i_len,
    output logic                        o_push,
    output lssm_pkg::t_entry            o_entry
);
    import lssm_pkg::*;

    logic [15:0]      r_bytes;
    logic [31:0]      r_line;
    logic [LEN_W-1:0] r_block;
    logic [15:0]      n_bytes;
    logic [31:0]      n_line;
    logic [LEN_W-1:0] n_block;

    logic [15:0]      len16;
    logic             do1;
    logic             do2;
    logic [15:0]      bil1;
    logic [15:0]      bil2;
    logic [LEN_W-1:0] ob1;
    logic [LEN_W-1:0] ob1p;
    logic [LEN_W-1:0] ob2;
    logic [LEN_W-1:0] ob2p;
    logic             c1;
    logic             c2;
    logic [15:0]      col1;
    logic [15:0]      col2;

    assign len16 = {10'd0, i_len};
    assign do1   = i_valid && (i_scan.shift != SHIFT_NONE);
    assign do2   = i_valid && (i_scan.shift == SHIFT_TWO);

    // First scanned byte, then the second one on top of its result.
    always_comb begin
        bil1 = (r_bytes == COL_MAX) ? COL_MAX : r_bytes + 16'd1;
        ob1  = (r_block != '0) ? r_block - 1'b1 : r_block;
        c1   = do1 && (ob1 == '0) && (bil1 >= len16) && i_scan.hit_a;
        col1 = (bil1 == COL_MAX) ? COL_MAX : bil1 - len16 + 16'd1;
        ob1p = c1 ? i_len : ob1;

        bil2 = (bil1 == COL_MAX) ? COL_MAX : bil1 + 16'd1;
        ob2  = (ob1p != '0) ? ob1p - 1'b1 : ob1p;
        c2   = do2 && (ob2 == '0) && (bil2 >= len16) && i_scan.hit_b;
        col2 = (bil2 == COL_MAX) ? COL_MAX : bil2 - len16 + 16'd1;
        ob2p = c2 ? i_len : ob2;
    end

    always_comb begin
        n_bytes = r_bytes;
        n_block = r_block;
        n_line  = r_line;
        if (do2) begin
            n_bytes = bil2;
            n_block = ob2p;
        end else if (do1) begin
            n_bytes = bil1;
            n_block = ob1p;
        end
        if (i_valid && i_scan.is_lf) begin
            n_line  = (r_line == LINE_MAX) ? LINE_MAX : r_line + 32'd1;
            n_bytes = '0;
            n_block = '0;
        end
        if (i_valid && i_scan.eof) begin
            n_line  = 32'd1;
            n_bytes = '0;
            n_block = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_line  <= 32'd1;
            r_block <= '0;
        end else begin
            r_bytes <= n_bytes;
            r_line  <= n_line;
            r_block <= n_block;
        end
    end

    always_comb begin
        o_push        = c1 || c2;
        o_entry.line  = r_line;
        o_entry.col_a = c1 ? col1 : col2;
        o_entry.col_b = col2;
        o_entry.two   = c1 && c2;
    end

endmodule

`default_nettype wire

>>> rtl/lssm_queue.sv
// ----------------------------------------------------------------------------
// lssm_queue
// Result queue; each entry carries one or two results and is drained one
// result per output transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module lssm_queue (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_push,
    input  wire lssm_pkg::t_entry          i_entry,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output lssm_pkg::t_out                 o_data,
    output logic [lssm_pkg::Q_CNT_W-1:0]   o_count
);
    import lssm_pkg::*;

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               r_second;
    logic [Q_CNT_W-1:0] n_count;
    logic               xfer;
    logic               pop;
    t_entry             head;

    assign head = r_mem[r_rd_ptr];
    assign xfer = o_valid && !i_stall;
    // An entry leaves once its last result has been transferred.
    assign pop  = xfer && (r_second || !head.two);

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_second <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
                r_second <= 1'b0;
            end else if (xfer) begin
                r_second <= 1'b1;
            end
        end
    end

    always_comb begin
        o_valid             = (r_count != '0);
        o_data.line_no      = head.line;
        o_data.start_column = r_second ? head.col_b : head.col_a;
        o_data.last_of_run  = r_second || !head.two;
        o_count             = r_count;
    end

endmodule

`default_nettype wire

>>> rtl/line_substring_match_scanner.sv
// ----------------------------------------------------------------------------
// line_substring_match_scanner
// Streaming per-line substring search over a byte stream.
// ----------------------------------------------------------------------------
// Bytes of a file enter on the input channel (i_in_valid / o_in_stall), one
// per transfer, with end_of_file set on the last byte. Each match of the
// configured pattern leaves on the output channel (o_out_valid / i_out_stall)
// as its line number and 1-based start column; last_of_run marks the final
// result caused by one input byte (a held-back CR can make it two).
// The pattern, its length and the case mode are written through the
// configuration channel, which is always ready; the user must write them only
// while no byte is in flight, as the block does not enforce it. A result is
// offered once its byte has passed the stage register and the tracking stage
// has written it into the result queue. Throughput: one byte per cycle while
// the input is not stalled; the row of 32 window cells compares all pattern
// positions at once. A byte giving two results needs two output transfers. The
// input stalls when the four-entry result queue, counting the entry still in
// the tracking stage, is full, so a stalled receiver backs up into the input.
// Reset sets the pattern to zero, the length and case mode to one, the line
// number to one and empties the queue and the window.
// ----------------------------------------------------------------------------
`default_nettype none

module line_substring_match_scanner (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire lssm_pkg::t_in                     i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output lssm_pkg::t_out                         o_out_data,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lssm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lssm_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import lssm_pkg::*;

    // Configuration registers.
    logic [CFG_DATA_W-1:0] r_pat [PAT_REGS];
    logic [LEN_W-1:0]      r_len;
    logic                  r_case;

    // Window side state and the stage register toward the tracker.
    logic                  r_pend;
    logic                  n_pend;
    logic                  r_s1_valid;
    t_scan                 r_s1;

    logic                  accept;
    logic                  is_lf;
    logic                  is_cr;
    t_shift                shift;
    logic [7:0]            x1;
    logic [7:0]            x2;

    logic [LEN_W-1:0]      len_eff;
    logic [PAT_IDX_W-1:0]  len_m1;
    logic [PAT_W-1:0]      pat_flat;
    logic [PAT_W-1:0]      pat_rev;
    logic [2*PAT_W-1:0]    pat_dbl;
    logic [2*PAT_W-1:0]    pat_shifted;
    logic [PAT_W-1:0]      pat_aligned;

    logic [7:0]            cell_byte [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] eq_a;
    logic [MAX_PATTERN-1:0] eq_b;
    logic [MAX_PATTERN-1:0] active;
    logic                  hit_a;
    logic                  hit_b;

    logic                  push;
    t_entry                entry;
    logic [Q_CNT_W-1:0]    q_count;
    logic [Q_CNT_W:0]      q_used;

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PAT_REGS; k++) begin
                r_pat[k] <= '0;
            end
            r_len  <= LEN_W'(1);
            r_case <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PAT_0: r_pat[0] <= i_cfg_data;
                CFG_PAT_1: r_pat[1] <= i_cfg_data;
                CFG_PAT_2: r_pat[2] <= i_cfg_data;
                CFG_PAT_3: r_pat[3] <= i_cfg_data;
                CFG_LEN:   r_len    <= i_cfg_data[LEN_W-1:0];
                CFG_CASE:  r_case   <= i_cfg_data[0];
                default:   ;
            endcase
        end
    end

    // Out of range lengths clamp to 1..MAX_PATTERN.
    always_comb begin
        if (r_len == '0) begin
            len_eff = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            len_eff = LEN_W'(MAX_PATTERN);
        end else begin
            len_eff = r_len;
        end
    end
    assign len_m1 = PAT_IDX_W'(len_eff - 1'b1);

    // Cell j compares against pattern byte (len - 1 - j): reverse the pattern
    // and rotate it by (32 - len) bytes.
    always_comb begin
        pat_flat = {r_pat[3], r_pat[2], r_pat[1], r_pat[0]};
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pat_rev[8*j +: 8] = pat_flat[8*(MAX_PATTERN-1-j) +: 8];
        end
        pat_dbl     = {pat_rev, pat_rev};
        pat_shifted = pat_dbl >> {~len_m1, 3'b000};
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pat_aligned[8*j +: 8] = fold_byte(pat_shifted[8*j +: 8], !r_case);
            active[j]             = (PAT_IDX_W'(j) <= len_m1);
        end
    end

    // ---------------- input side ----------------
    assign q_used     = {1'b0, q_count} + (Q_CNT_W+1)'(r_s1_valid);
    assign o_in_stall = (q_used >= (Q_CNT_W+1)'(Q_DEPTH));
    assign accept     = i_in_valid && !o_in_stall;
    assign is_lf      = (i_in_data.data_byte == LF_BYTE);
    assign is_cr      = (i_in_data.data_byte == CR_BYTE);

    // A CR is held back until the next byte shows whether it ends the line.
    always_comb begin
        shift  = SHIFT_NONE;
        x1     = i_in_data.data_byte;
        x2     = i_in_data.data_byte;
        n_pend = r_pend;
        if (accept) begin
            if (is_lf) begin
                n_pend = 1'b0;
            end else if (r_pend) begin
                x1 = CR_BYTE;
                if (is_cr) begin
                    shift  = SHIFT_ONE;
                    n_pend = 1'b1;
                end else begin
                    shift  = SHIFT_TWO;
                    n_pend = 1'b0;
                end
            end else if (is_cr) begin
                n_pend = 1'b1;
            end else begin
                shift = SHIFT_ONE;
            end
            if (i_in_data.end_of_file) begin
                n_pend = 1'b0;
            end
        end
    end

    // ---------------- cell row ----------------
    for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
        logic [7:0] prev1;
        logic [7:0] prev2;
        if (j == 0) begin : g_first
            assign prev1 = x1;
            assign prev2 = x2;
        end else if (j == 1) begin : g_second
            assign prev1 = cell_byte[0];
            assign prev2 = x1;
        end else begin : g_rest
            assign prev1 = cell_byte[j-1];
            assign prev2 = cell_byte[j-2];
        end

        lssm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (shift),
            .i_prev1   (prev1),
            .i_prev2   (prev2),
            .i_pat     (pat_aligned[8*j +: 8]),
            .i_fold_en (!r_case),
            .o_byte    (cell_byte[j]),
            .o_eq_a    (eq_a[j]),
            .o_eq_b    (eq_b[j])
        );
    end

    assign hit_a = &(eq_a | ~active);
    assign hit_b = &(eq_b | ~active);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend     <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            r_pend     <= n_pend;
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.shift <= shift;
            r_s1.hit_a <= hit_a;
            r_s1.hit_b <= hit_b;
            r_s1.is_lf <= is_lf;
            r_s1.eof   <= i_in_data.end_of_file;
        end
    end

    // ---------------- tracking and results ----------------
    lssm_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_scan  (r_s1),
        .i_len   (len_eff),
        .o_push  (push),
        .o_entry (entry)
    );

    lssm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_data),
        .o_count (q_count)
    );

endmodule

`default_nettype wire
